// File: rtl/slcr_pkg.sv
// shared command codes and controller/datapath command-status types for the sprite line renderer
package slcr_pkg;

    localparam logic [2:0] CMD_BEGIN_LINE = 3'd0;
    localparam logic [2:0] CMD_DRAW_ROW   = 3'd1;
    localparam logic [2:0] CMD_READ_PIXEL = 3'd2;
    localparam logic [2:0] CMD_SET_MASK   = 3'd3;
    localparam logic [2:0] CMD_END_FRAME  = 3'd4;
    localparam logic [2:0] CMD_READ_COLL  = 3'd5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the transaction fields
        logic clr_step;    // one begin-line clear step at the sweep counter
        logic draw_rd;     // read owner at the draw column
        logic draw_wr;     // resolve the draw pixel read last cycle
        logic pix_rd;      // read pixel memory
        logic set_mask;
        logic mask_rd;     // read both collision masks and both frame table entries
        logic coll_or;     // or the fetched masks into the frame table
        logic frame_step;  // end-frame latch and clear at the sweep counter
        logic coll_rd;     // read latched table
        logic ctr_clr;
        logic ctr_inc;
        logic result;      // strobe the read result
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic ctr_last_line;    // sweep counter at the last pixel
        logic ctr_last_sprite;  // sweep counter at the last sprite
        logic ctr_last_bit;     // draw counter at the last bit of the row
        logic draw_skip;        // draw transaction does nothing
        logic pix_hit;          // current draw bit is set and inside the line
        logic owned;            // owner read back is a valid sprite
    } t_dp_stat;

endpackage

// File: rtl/sprite_line_collision_renderer_top.sv
// top level of the sprite line renderer with collision tracking
// A transaction is taken when start is high and busy is low; busy then stays high until the
// command is done. After reset busy stays high while the line and owner memories are cleared.
// Begin-line sweeps the line and owner memories one pixel a cycle; end-frame sweeps the
// collision tables. In a draw row each set bit inside the line is a read-modify-write on the
// single-port owner memory, followed by a mask read and a frame table update when the pixel
// already has an owner. Reads give read_data with o_result_valid for one cycle, after the
// decode and read-wait states and the result register; the receiver cannot stall it. The
// background color register is written through its own valid/ready channel, always ready.
module sprite_line_collision_renderer_top
    import slcr_pkg::*;
#(
    parameter int LINE_PIXELS   = 640,
    parameter int SPRITE_COUNT  = 32,
    parameter int MAX_ROW_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_bitmap,
    input  logic [5:0]  i_row_width,
    input  logic signed [15:0] i_x_position,
    input  logic [4:0]  i_sprite_index,
    input  logic [15:0] i_pixel_color,
    input  logic [9:0]  i_pixel_index,
    input  logic [31:0] i_mask_value,
    output logic        o_result_valid,
    output logic [31:0] o_read_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;
    logic [15:0] r_background;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_background <= 16'd0;
        end else if (i_cfg_valid) begin
            r_background <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    slcr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_busy    (busy)
    );

    slcr_datapath #(
        .LINE_PIXELS   (LINE_PIXELS),
        .SPRITE_COUNT  (SPRITE_COUNT),
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_background_color (r_background),
        .i_bitmap           (i_bitmap),
        .i_row_width        (i_row_width),
        .i_x_position       (i_x_position),
        .i_sprite_index     (i_sprite_index),
        .i_pixel_color      (i_pixel_color),
        .i_pixel_index      (i_pixel_index),
        .i_mask_value       (i_mask_value),
        .o_result_valid     (o_result_valid),
        .o_read_data        (o_read_data)
    );
endmodule

// File: rtl/slcr_datapath.sv
// datapath: line, owner and collision memories with the fields of the current transaction
module slcr_datapath
    import slcr_pkg::*;
#(
    parameter int LINE_PIXELS   = 640,
    parameter int SPRITE_COUNT  = 32,
    parameter int MAX_ROW_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [15:0] i_background_color,
    input  logic [31:0] i_bitmap,
    input  logic [5:0]  i_row_width,
    input  logic [15:0] i_x_position,
    input  logic [4:0]  i_sprite_index,
    input  logic [15:0] i_pixel_color,
    input  logic [9:0]  i_pixel_index,
    input  logic [31:0] i_mask_value,
    output logic        o_result_valid,
    output logic [31:0] o_read_data
);
    localparam int PW  = $clog2(LINE_PIXELS);
    localparam int SW  = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int CW  = (PW > SW) ? PW + 1 : SW + 1;

    logic [15:0] line_mem  [LINE_PIXELS];
    logic [5:0]  owner_mem [LINE_PIXELS];
    logic [31:0] mask_mem  [SPRITE_COUNT];
    logic [31:0] frame_mem [SPRITE_COUNT];
    logic [31:0] latch_mem [SPRITE_COUNT];
    logic [SPRITE_COUNT-1:0] r_mask_vld, r_frame_vld, r_latch_vld;

    logic [31:0] r_bitmap;
    logic [5:0]  r_width;
    logic signed [16:0] r_x;
    logic [4:0]  r_id;
    logic [15:0] r_color;
    logic [9:0]  r_pix_idx;
    logic [31:0] r_mask_in;
    logic [CW-1:0] r_ctr;
    logic [5:0]  r_owner;
    logic [PW-1:0] r_col;
    logic [31:0] r_own_mask, r_oth_mask;
    logic [SW-1:0] r_other;
    logic [31:0] r_frame_a, r_frame_b;
    logic        r_rd_pix, r_result;
    logic [31:0] w_data;
    logic [15:0] r_pix_q;
    logic [31:0] r_latch_q;

    logic [5:0]  w_width_sat;
    logic signed [17:0] w_col;
    logic        w_col_in;
    logic [5:0]  w_bitpos;
    logic        w_id_ok;
    logic [PW-1:0] w_col_idx;
    logic [SW-1:0] w_ctr_s, w_id_s;

    assign w_width_sat = (r_width > 6'(MAX_ROW_WIDTH)) ? 6'(MAX_ROW_WIDTH) : r_width;
    assign w_col    = 18'(r_x) + 18'(r_ctr);
    assign w_col_in = (w_col >= 0) && (w_col < 18'(LINE_PIXELS));
    assign w_col_idx = w_col[PW-1:0];
    assign w_bitpos = w_width_sat - 6'd1 - 6'(r_ctr);
    assign w_id_ok  = 32'(r_id) < 32'(SPRITE_COUNT);
    assign w_ctr_s  = r_ctr[SW-1:0];
    assign w_id_s   = SW'(r_id);

    assign o_stat.ctr_last_line   = r_ctr == CW'(LINE_PIXELS - 1);
    assign o_stat.ctr_last_sprite = r_ctr == CW'(SPRITE_COUNT - 1);
    assign o_stat.ctr_last_bit    = r_ctr == CW'(w_width_sat - 6'd1);
    assign o_stat.draw_skip       = !w_id_ok || (r_width == 6'd0);
    assign o_stat.pix_hit         = w_col_in && r_bitmap[w_bitpos[4:0]];
    assign o_stat.owned           = (r_owner != 6'd0) && (32'(r_owner) <= 32'(SPRITE_COUNT));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bitmap  <= i_bitmap;
            r_width   <= i_row_width;
            r_x       <= 17'(signed'(i_x_position));
            r_id      <= i_sprite_index;
            r_color   <= i_pixel_color;
            r_pix_idx <= i_pixel_index;
            r_mask_in <= i_mask_value;
        end
        if (i_cmd.ctr_clr) begin
            r_ctr <= '0;
        end else if (i_cmd.ctr_inc) begin
            r_ctr <= r_ctr + CW'(1);
        end
        // line and owner memories
        if (i_cmd.clr_step) begin
            line_mem[r_ctr[PW-1:0]]  <= i_background_color;
            owner_mem[r_ctr[PW-1:0]] <= 6'd0;
        end else if (i_cmd.draw_wr && !o_stat.owned) begin
            line_mem[r_col]  <= r_color;
            owner_mem[r_col] <= 6'(r_id) + 6'd1;
        end
        if (i_cmd.draw_rd) begin
            r_owner <= owner_mem[w_col_idx];
            r_col   <= w_col_idx;
        end
        if (i_cmd.pix_rd) begin
            r_pix_q <= line_mem[PW'(r_pix_idx)];
        end
        if (i_cmd.draw_wr) begin
            r_other <= SW'(r_owner - 6'd1);
        end
        if (i_cmd.mask_rd) begin
            r_own_mask <= r_mask_vld[w_id_s] ? mask_mem[w_id_s] : 32'd0;
            r_oth_mask <= r_mask_vld[r_other] ? mask_mem[r_other] : 32'd0;
            r_frame_a  <= r_frame_vld[r_other] ? frame_mem[r_other] : 32'd0;
            r_frame_b  <= r_frame_vld[w_id_s] ? frame_mem[w_id_s] : 32'd0;
        end
        if (i_cmd.set_mask && w_id_ok) begin
            mask_mem[w_id_s] <= r_mask_in;
        end
        if (i_cmd.coll_or) begin
            if (r_other == w_id_s) begin
                frame_mem[w_id_s] <= r_frame_b | r_own_mask | r_oth_mask;
            end else begin
                frame_mem[r_other] <= r_frame_a | r_own_mask;
                frame_mem[w_id_s]  <= r_frame_b | r_oth_mask;
            end
        end
        if (i_cmd.frame_step) begin
            latch_mem[w_ctr_s] <= r_frame_vld[w_ctr_s] ? frame_mem[w_ctr_s] : 32'd0;
        end
        if (i_cmd.coll_rd) begin
            r_latch_q <= r_latch_vld[w_id_s] ? latch_mem[w_id_s] : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_vld  <= '0;
            r_frame_vld <= '0;
            r_latch_vld <= '0;
            r_rd_pix    <= 1'b0;
            r_result    <= 1'b0;
        end else begin
            if (i_cmd.set_mask && w_id_ok) begin
                r_mask_vld[w_id_s] <= 1'b1;
            end
            if (i_cmd.coll_or) begin
                r_frame_vld[w_id_s]  <= 1'b1;
                r_frame_vld[r_other] <= 1'b1;
            end
            if (i_cmd.frame_step) begin
                r_latch_vld[w_ctr_s] <= 1'b1;
                r_frame_vld[w_ctr_s] <= 1'b0;
            end
            if (i_cmd.pix_rd) begin
                r_rd_pix <= 1'b1;
            end else if (i_cmd.coll_rd) begin
                r_rd_pix <= 1'b0;
            end
            r_result <= i_cmd.result;
        end
    end

    // out of range reads answer zero
    always_comb begin
        if (r_rd_pix) begin
            w_data = (32'(r_pix_idx) < 32'(LINE_PIXELS)) ? {16'd0, r_pix_q} : 32'd0;
        end else begin
            w_data = w_id_ok ? r_latch_q : 32'd0;
        end
    end

    assign o_result_valid = r_result;
    assign o_read_data    = w_data;
endmodule

// File: rtl/slcr_ctrl.sv
// controller state machine sequencing each command over the datapath
module slcr_ctrl
    import slcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_command,
    input  t_dp_stat    i_stat,
    output t_dp_cmd     o_cmd,
    output logic        o_busy
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_CLEAR  = 4'd2;
    localparam logic [3:0] S_DRAW   = 4'd3;
    localparam logic [3:0] S_RESOLV = 4'd4;
    localparam logic [3:0] S_MASK   = 4'd5;
    localparam logic [3:0] S_OR     = 4'd6;
    localparam logic [3:0] S_FRAME  = 4'd7;
    localparam logic [3:0] S_RDWAIT = 4'd8;
    localparam logic [3:0] S_NEXT   = 4'd9;
    localparam logic [3:0] S_INIT   = 4'd10;

    logic [3:0] r_state, n_state;
    logic [2:0] r_cmd, n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cmd   <= CMD_BEGIN_LINE;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        o_cmd   = '0;
        unique case (r_state)
            // line and owner memories are cleared by one sweep after reset
            S_INIT: begin
                o_cmd.ctr_clr = 1'b1;
                n_state = S_CLEAR;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.ctr_clr = 1'b1;
                    n_cmd   = i_command;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_cmd)
                    CMD_BEGIN_LINE: n_state = S_CLEAR;
                    CMD_DRAW_ROW:   n_state = i_stat.draw_skip ? S_IDLE : S_DRAW;
                    CMD_READ_PIXEL: begin
                        o_cmd.pix_rd = 1'b1;
                        n_state = S_RDWAIT;
                    end
                    CMD_SET_MASK: begin
                        o_cmd.set_mask = 1'b1;
                        n_state = S_IDLE;
                    end
                    CMD_END_FRAME:  n_state = S_FRAME;
                    CMD_READ_COLL: begin
                        o_cmd.coll_rd = 1'b1;
                        n_state = S_RDWAIT;
                    end
                    default:        n_state = S_IDLE;
                endcase
            end
            S_RDWAIT: begin
                o_cmd.result = 1'b1;
                n_state = S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.ctr_inc  = 1'b1;
                if (i_stat.ctr_last_line) n_state = S_IDLE;
            end
            S_FRAME: begin
                o_cmd.frame_step = 1'b1;
                o_cmd.ctr_inc    = 1'b1;
                if (i_stat.ctr_last_sprite) n_state = S_IDLE;
            end
            S_DRAW: begin
                if (i_stat.pix_hit) begin
                    o_cmd.draw_rd = 1'b1;
                    n_state = S_RESOLV;
                end else begin
                    o_cmd.ctr_inc = 1'b1;
                    if (i_stat.ctr_last_bit) n_state = S_IDLE;
                end
            end
            S_RESOLV: begin
                o_cmd.draw_wr = 1'b1;
                n_state = i_stat.owned ? S_MASK : S_NEXT;
            end
            S_MASK: begin
                o_cmd.mask_rd = 1'b1;
                n_state = S_OR;
            end
            S_OR: begin
                o_cmd.coll_or = 1'b1;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.ctr_inc = 1'b1;
                n_state = i_stat.ctr_last_bit ? S_IDLE : S_DRAW;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = r_state != S_IDLE;
endmodule

// File: rtl/slcr_checker.sv
// port-level checker for the sprite line renderer, bound to the top level
module slcr_checker
    import slcr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_command,
    input logic        o_result_valid
);
    // an accepted transaction makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    // a result only comes while a transaction is in flight
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy, 1)) else $error("result while idle");
    // results last one cycle
    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid) else $error("result held");
    // an accepted read transaction gives its result after the decode and read-wait states and the result register
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_command == CMD_READ_PIXEL || i_command == CMD_READ_COLL)
        |=> ##2 o_result_valid)
        else $error("read result missing");
endmodule

bind sprite_line_collision_renderer_top slcr_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_command      (i_command),
    .o_result_valid (o_result_valid)
);

// File: sim/sprite_line_collision_renderer_top_test.sv
// testbench for the sprite line renderer: directed table, then random frames checked by a predictor
module sprite_line_collision_renderer_top_test;
    import slcr_pkg::*;

    localparam int LINE_LEN   = 640;
    localparam int SPRITES    = 32;
    localparam int ROW_MAX    = 32;
    localparam int STALL_MAX  = 5000;

    typedef struct {
        logic [2:0]         cmd;
        logic [31:0]        bmp;
        logic [5:0]         width;
        logic signed [15:0] xpos;
        logic [4:0]         id;
        logic [15:0]        color;
        logic [9:0]         pidx;
        logic [31:0]        mask;
        bit                 typed;
        logic [31:0]        value;
    } req_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_command;
    logic [31:0] i_bitmap;
    logic [5:0]  i_row_width;
    logic signed [15:0] i_x_position;
    logic [4:0]  i_sprite_index;
    logic [15:0] i_pixel_color;
    logic [9:0]  i_pixel_index;
    logic [31:0] i_mask_value;
    logic        o_result_valid;
    logic [31:0] o_read_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    sprite_line_collision_renderer_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_bitmap       (i_bitmap),
        .i_row_width    (i_row_width),
        .i_x_position   (i_x_position),
        .i_sprite_index (i_sprite_index),
        .i_pixel_color  (i_pixel_color),
        .i_pixel_index  (i_pixel_index),
        .i_mask_value   (i_mask_value),
        .o_result_valid (o_result_valid),
        .o_read_data    (o_read_data),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // predictor state
    logic [15:0] bg_color;
    logic [15:0] line_mem [LINE_LEN];
    logic [5:0]  owner_mem [LINE_LEN];
    bit          pix_written [LINE_LEN];
    logic [31:0] sprite_masks [SPRITES];
    logic [31:0] frame_hits [SPRITES];
    logic [31:0] latched_hits [SPRITES];

    logic [31:0] expected_reads [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // paint one sprite row into the predicted line and record overlaps
    task automatic paint_row(input req_t r);
        int w;
        int c;
        int other;
        w = (r.width > ROW_MAX) ? ROW_MAX : int'(r.width);
        for (int i = 0; i < w; i++) begin
            c = int'(r.xpos) + i;
            if (c < 0 || c >= LINE_LEN) continue;
            if (!r.bmp[w - 1 - i]) continue;
            if (owner_mem[c] != 0) begin
                other = owner_mem[c] - 1;
                frame_hits[other] |= sprite_masks[r.id];
                frame_hits[r.id]  |= sprite_masks[other];
            end else begin
                line_mem[c]    = r.color;
                owner_mem[c]   = r.id + 6'd1;
                pix_written[c] = 1'b1;
            end
        end
    endtask

    task automatic render_predict(input req_t r);
        logic [31:0] v;
        case (r.cmd)
            CMD_BEGIN_LINE: begin
                for (int i = 0; i < LINE_LEN; i++) begin
                    line_mem[i]    = bg_color;
                    owner_mem[i]   = '0;
                    pix_written[i] = 1'b1;
                end
            end
            CMD_DRAW_ROW: paint_row(r);
            CMD_READ_PIXEL: begin
                v = (r.pidx < LINE_LEN) ? {16'd0, line_mem[r.pidx]} : 32'd0;
                expected_reads.push_back(r.typed ? r.value : v);
            end
            CMD_SET_MASK: sprite_masks[r.id] = r.mask;
            CMD_END_FRAME: begin
                for (int i = 0; i < SPRITES; i++) begin
                    latched_hits[i] = frame_hits[i];
                    frame_hits[i]   = '0;
                end
            end
            CMD_READ_COLL: expected_reads.push_back(r.typed ? r.value : latched_hits[r.id]);
            default: ;
        endcase
    endtask

    task automatic issue(input req_t r);
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        start          <= 1'b1;
        i_command      <= r.cmd;
        i_bitmap       <= r.bmp;
        i_row_width    <= r.width;
        i_x_position   <= r.xpos;
        i_sprite_index <= r.id;
        i_pixel_color  <= r.color;
        i_pixel_index  <= r.pidx;
        i_mask_value   <= r.mask;
        do @(posedge i_clk); while (busy);
        render_predict(r);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_reads.size() != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_background(input logic [15:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        bg_color = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic req_t mk(input logic [2:0] cmd, input logic [31:0] bmp,
                                input logic [5:0] width, input logic signed [15:0] xpos,
                                input logic [4:0] id, input logic [15:0] color,
                                input logic [9:0] pidx, input logic [31:0] mask,
                                input bit typed, input logic [31:0] value);
        req_t r;
        r.cmd = cmd; r.bmp = bmp; r.width = width; r.xpos = xpos; r.id = id;
        r.color = color; r.pidx = pidx; r.mask = mask; r.typed = typed; r.value = value;
        return r;
    endfunction

    function automatic req_t random_req(input logic [2:0] cmd);
        req_t r;
        r = mk(cmd, $urandom, 6'($urandom_range(1, ROW_MAX)),
               16'($urandom_range(0, LINE_LEN + 40) - 20), 5'($urandom_range(0, 7)),
               16'($urandom), 10'($urandom_range(0, 1023)), $urandom, 1'b0, '0);
        if ($urandom_range(9) == 0) r.width = 6'($urandom);
        if ($urandom_range(9) == 0) r.xpos = 16'($urandom);
        if ($urandom_range(4) == 0) r.id = 5'($urandom);
        if (r.cmd == CMD_READ_PIXEL && r.pidx < LINE_LEN && !pix_written[r.pidx])
            r.pidx = 10'd640 + 10'(r.pidx[7:0]);
        return r;
    endfunction

    // one frame: masks, one or two lines of draws and reads, usually end frame, table reads, maybe noise
    task automatic random_frame(output int sent);
        int lines;
        sent = 0;
        for (int i = 0; i < $urandom_range(0, 4); i++) begin
            issue(random_req(CMD_SET_MASK)); sent++;
        end
        lines = $urandom_range(1, 2);
        for (int l = 0; l < lines; l++) begin
            issue(random_req(CMD_BEGIN_LINE)); sent++;
            for (int i = 0; i < $urandom_range(2, 8); i++) begin
                issue(random_req(CMD_DRAW_ROW)); sent++;
                if ($urandom_range(1)) begin
                    issue(random_req(CMD_READ_PIXEL)); sent++;
                end
            end
        end
        if ($urandom_range(7) != 0) begin
            issue(random_req(CMD_END_FRAME)); sent++;
        end
        for (int i = 0; i < $urandom_range(1, 4); i++) begin
            issue(random_req(CMD_READ_COLL)); sent++;
        end
        // some noise: any command with random fields
        if ($urandom_range(3) == 0) begin
            issue(random_req(3'($urandom))); sent++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_reads.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected read result %h", o_read_data);
            end else begin
                logic [31:0] want;
                want = expected_reads.pop_front();
                if (o_read_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("read_data mismatch: expected %h got %h", want, o_read_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("[sprite_line_collision_renderer_top] ERROR");
            $finish;
        end
    end

    initial begin
        req_t dir [$];
        logic [15:0] bg_values [3];
        int sent;
        int n;

        mismatch_count = 0;
        stall_cycles   = 0;
        send_idle_pct  = 8;
        start = 1'b0; i_command = '0; i_bitmap = '0; i_row_width = '0; i_x_position = '0;
        i_sprite_index = '0; i_pixel_color = '0; i_pixel_index = '0; i_mask_value = '0;
        i_cfg_valid = 1'b0; i_cfg_data = '0;
        bg_color = '0;
        for (int i = 0; i < LINE_LEN; i++) begin
            line_mem[i] = '0; owner_mem[i] = '0; pix_written[i] = 1'b0;
        end
        for (int i = 0; i < SPRITES; i++) begin
            sprite_masks[i] = '0; frame_hits[i] = '0; latched_hits[i] = '0;
        end

        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_background(16'hFFFF);

        // directed rows
        dir.push_back(mk(CMD_READ_COLL, 0, 0, 0, 5'd0, 0, 0, 0, 1, 32'd0));
        dir.push_back(mk(CMD_READ_COLL, 0, 0, 0, 5'd31, 0, 0, 0, 1, 32'd0));
        dir.push_back(mk(CMD_BEGIN_LINE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_READ_PIXEL, 0, 0, 0, 0, 0, 10'd0, 0, 1, 32'h0000_FFFF));
        dir.push_back(mk(CMD_READ_PIXEL, 0, 0, 0, 0, 0, 10'd639, 0, 1, 32'h0000_FFFF));
        dir.push_back(mk(CMD_READ_PIXEL, 0, 0, 0, 0, 0, 10'd1023, 0, 1, 32'd0));
        dir.push_back(mk(CMD_SET_MASK, 0, 0, 0, 5'd0, 0, 0, 32'hFFFF_FFFF, 0, 0));
        dir.push_back(mk(CMD_SET_MASK, 0, 0, 0, 5'd31, 0, 0, 32'h8000_0000, 0, 0));
        // clipped on the left, then saturated width clipped on the right
        dir.push_back(mk(CMD_DRAW_ROW, 32'hFFFF_FFFF, 6'd32, -16'sd16, 5'd0, 16'h1234, 0, 0, 0, 0));
        dir.push_back(mk(CMD_DRAW_ROW, 32'hFFFF_FFFF, 6'd63, 16'sd620, 5'd31, 16'hABCD, 0, 0, 0, 0));
        dir.push_back(mk(CMD_DRAW_ROW, 32'hFFFF_FFFF, 6'd0, 16'sd300, 5'd31, 16'h0000, 0, 0, 0, 0));
        dir.push_back(mk(CMD_DRAW_ROW, 32'h0000_0001, 6'd1, 16'sd0, 5'd31, 16'h5555, 0, 0, 0, 0));
        // stray high bit ignored, and a sprite drawing over itself
        dir.push_back(mk(CMD_DRAW_ROW, 32'h8000_0001, 6'd2, 16'sd1, 5'd0, 16'h0F0F, 0, 0, 0, 0));
        dir.push_back(mk(CMD_DRAW_ROW, 32'hFFFF_FFFF, 6'd32, -16'sd32768, 5'd3, 16'h7777, 0, 0, 0, 0));
        dir.push_back(mk(CMD_DRAW_ROW, 32'hFFFF_FFFF, 6'd32, 16'sd32767, 5'd3, 16'h7777, 0, 0, 0, 0));
        dir.push_back(mk(CMD_READ_PIXEL, 0, 0, 0, 0, 0, 10'd5, 0, 0, 0));
        dir.push_back(mk(CMD_READ_PIXEL, 0, 0, 0, 0, 0, 10'd630, 0, 0, 0));
        dir.push_back(mk(CMD_READ_PIXEL, 0, 0, 0, 0, 0, 10'd100, 0, 0, 0));
        dir.push_back(mk(3'd6, 32'hFFFF_FFFF, 6'd63, 16'sd0, 5'd31, 16'hFFFF, 10'd1023, '1, 0, 0));
        dir.push_back(mk(3'd7, 32'hFFFF_FFFF, 6'd63, 16'sd0, 5'd31, 16'hFFFF, 10'd1023, '1, 0, 0));
        dir.push_back(mk(CMD_END_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_READ_COLL, 0, 0, 0, 5'd0, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_READ_COLL, 0, 0, 0, 5'd31, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_READ_COLL, 0, 0, 0, 5'd5, 0, 0, 0, 0, 0));
        foreach (dir[i]) issue(dir[i]);

        bg_values[0] = 16'h0000;
        bg_values[1] = 16'($urandom);
        bg_values[2] = 16'hFFFF;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 79 : 0;
            write_background(bg_values[ph]);
            n = 0;
            while (n < 460) begin
                random_frame(sent);
                n += sent;
            end
        end

        wait_idle();
        if (mismatch_count == 0 && expected_reads.size() == 0) begin
            $display("[sprite_line_collision_renderer_top] OK");
        end else begin
            $display("[sprite_line_collision_renderer_top] ERROR");
        end
        $finish;
    end

endmodule
